// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define CHK_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CHK_IMP(lbl, clk, rst, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hdl/jips_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler package
// Widths, codes, register map, shared types and the seed mixing function.
// ----------------------------------------------------------------------------
package jips_pkg;

  // Field widths.
  localparam int NOW_W      = 64;
  localparam int SEQ_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int MIX_W      = 32;
  localparam int DIV_STEPS  = MIX_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Register map.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_QUIET  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_SPAN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_SPAN = 8'd3;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] MIN_QUIET_RST  = 16'd7000;
  localparam logic [CFG_DATA_W-1:0] QUIET_SPAN_RST = 16'd11000;
  localparam logic [CFG_DATA_W-1:0] PULSE_MIN_RST  = 16'd320;
  localparam logic [CFG_DATA_W-1:0] PULSE_SPAN_RST = 16'd520;

  // Seed multipliers.
  localparam logic [SEQ_W-1:0] QUIET_MULT = 32'h9E37_79B9;
  localparam logic [SEQ_W-1:0] PULSE_MULT = 32'h85EB_CA6B;

  // Display state codes on the input side.
  localparam logic [1:0] DISP_IDLE      = 2'd0;
  localparam logic [1:0] DISP_ATTENTIVE = 2'd1;

  // Command codes on the output side.
  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_IDLE      = 2'd1;
  localparam logic [1:0] CMD_ATTENTIVE = 2'd2;

  // Configuration register set.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] min_quiet;
    logic [CFG_DATA_W-1:0] quiet_span;
    logic [CFG_DATA_W-1:0] pulse_min;
    logic [CFG_DATA_W-1:0] pulse_span;
  } cfg_t;

  // Request to the deadline draw unit.
  typedef struct packed {
    logic             start;
    logic             is_pulse;
    logic [NOW_W-1:0] now;
    logic [SEQ_W-1:0] seq;
  } draw_req_t;

  // Response from the deadline draw unit.
  typedef struct packed {
    logic             done;
    logic [NOW_W-1:0] deadline;
  } draw_rsp_t;

  // Tick sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PULSE,
    ST_CHECK,
    ST_DRAW,
    ST_DONE
  } seq_state_t;

  // Draw unit states.
  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL,
    D_MIX,
    D_DIV,
    D_SUM
  } draw_state_t;

  // Fold a 64-bit seed to 32 bits and run the 13/17/5 xorshift.
  function automatic logic [MIX_W-1:0] scramble(input logic [NOW_W-1:0] seed);
    logic [MIX_W-1:0] x;
    x = seed[MIX_W-1:0] ^ seed[NOW_W-1:MIX_W];
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// File: hdl/jips_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler channels
// Valid/ready channels for ticks, results and configuration writes.
// ----------------------------------------------------------------------------

// Tick channel: one request per time tick.
interface jips_tick_if import jips_pkg::*;;
  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_ms;
  logic             interaction;
  logic             attention;
  logic [1:0]       requested_state;

  modport source (output valid, now_ms, interaction, attention, requested_state,
                  input ready);
  modport sink   (input valid, now_ms, interaction, attention, requested_state,
                  output ready);
endinterface

// Result channel: one result per tick.
interface jips_result_if import jips_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       state_command;
  logic             pulse_on;
  logic [SEQ_W-1:0] sequence_out;

  modport source (output valid, state_command, pulse_on, sequence_out, input ready);
  modport sink   (input valid, state_command, pulse_on, sequence_out, output ready);
endinterface

// Configuration write channel.
interface jips_cfg_if import jips_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/jips_draw.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline draw unit
// Builds a seed from time and sequence, mixes it, reduces it modulo the span
// with a bit-serial restoring divider and adds it to the time with saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jips_draw import jips_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  draw_req_t req,
  output draw_rsp_t rsp
);

  draw_state_t dstate, dstate_next;

  logic                  is_pulse;
  logic [NOW_W-1:0]      now_r;
  logic [SEQ_W-1:0]      seq_r;
  logic [NOW_W-1:0]      prod;
  logic [MIX_W-1:0]      mix;
  logic [CFG_DATA_W-1:0] rem;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [NOW_W-1:0]      deadline;
  logic                  done;

  logic [SEQ_W-1:0]      mult_sel;
  logic [CFG_DATA_W-1:0] span_sel;
  logic [CFG_DATA_W-1:0] base_sel;
  logic [NOW_W-1:0]      seed;
  logic [CFG_DATA_W:0]   trial;
  logic                  trial_ge;
  logic [CFG_DATA_W-1:0] extra;
  logic [CFG_DATA_W:0]   offset;
  logic [NOW_W:0]        sum;

  // Operand selection by draw kind.
  assign mult_sel = is_pulse ? PULSE_MULT : QUIET_MULT;
  assign span_sel = is_pulse ? cfg.pulse_span : cfg.quiet_span;
  assign base_sel = is_pulse ? cfg.pulse_min : cfg.min_quiet;

  // Seed: time plus scaled sequence, or doubled time xor scaled sequence.
  assign seed = is_pulse ? ({now_r[NOW_W-2:0], 1'b0} ^ prod) : (now_r + prod);

  // One restoring division step: bring down the next bit and try the span.
  assign trial    = {rem, mix[MIX_W-1]};
  assign trial_ge = trial >= {1'b0, span_sel};

  // Final offset and saturating add; a zero span gives no extra time.
  assign extra  = (span_sel == '0) ? '0 : rem;
  assign offset = {1'b0, base_sel} + {1'b0, extra};
  assign sum    = {1'b0, now_r} + {{(NOW_W-CFG_DATA_W){1'b0}}, offset};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
    end else begin
      dstate <= dstate_next;
    end
  end

  // Next state.
  always_comb begin
    dstate_next = dstate;
    case (dstate)
      D_IDLE:  if (req.start) dstate_next = D_MUL;
      D_MUL:   dstate_next = D_MIX;
      D_MIX:   dstate_next = D_DIV;
      D_DIV:   if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) dstate_next = D_SUM;
      D_SUM:   dstate_next = D_IDLE;
      default: dstate_next = D_IDLE;
    endcase
  end

  // Completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (dstate == D_SUM);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (dstate)
      D_IDLE: begin
        if (req.start) begin
          is_pulse <= req.is_pulse;
          now_r    <= req.now;
          seq_r    <= req.seq;
        end
      end
      D_MUL: begin
        prod <= seq_r * mult_sel;
      end
      D_MIX: begin
        mix <= scramble(seed);
        rem <= '0;
        cnt <= '0;
      end
      D_DIV: begin
        rem <= trial_ge ? CFG_DATA_W'(trial - {1'b0, span_sel}) : trial[CFG_DATA_W-1:0];
        mix <= {mix[MIX_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      D_SUM: begin
        deadline <= sum[NOW_W] ? {NOW_W{1'b1}} : sum[NOW_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign rsp.done     = done;
  assign rsp.deadline = deadline;

  `CHK_IMP(a_start_when_free, clk, rst, req.start, dstate == D_IDLE, "draw started while busy")
  `CHK_IMP(a_rem_below_span, clk, rst, (dstate == D_DIV) && (span_sel != '0), rem < span_sel, "remainder not below span")
  `CHK_IMP(a_deadline_not_early, clk, rst, done, deadline >= now_r, "deadline before time")

endmodule

// File: hdl/jittered_idle_pulse_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jittered idle pulse scheduler
// Per tick, starts, ends or cancels a presence pulse against jittered
// quiet and pulse deadlines, and reports the command and sequence count.
// ----------------------------------------------------------------------------
// A tick request is taken only while the sequencer is idle; it then passes
// the pulse, check and done states, with a wait in the draw state for each
// deadline draw, and its result is registered as it leaves the done state.
// A tick needs at most two draws: the first tick after reset draws the
// initial quiet deadline and then possibly a pulse or a fresh quiet deadline,
// and an ending pulse may be followed by a redraw. Each draw in the shared
// draw unit runs one multiply, one mix, 32 bit-serial modulo steps and one
// saturating add. Ticks may be accepted while the previous result still waits.
// Configuration writes are always accepted and must arrive only when idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jittered_idle_pulse_scheduler import jips_pkg::*; (
  input logic          clk,
  input logic          rst,
  jips_cfg_if.sink     cfg,
  jips_tick_if.sink    tick,
  jips_result_if.source result
);

  seq_state_t state, state_next;
  seq_state_t ret_state, ret_state_next;

  cfg_t             cfg_regs;
  logic             pulse_flag;
  logic [NOW_W-1:0] pulse_end;
  logic [NOW_W-1:0] next_quiet;
  logic [SEQ_W-1:0] seq_count;
  logic             started;

  // Latched tick.
  logic [NOW_W-1:0] now_r;
  logic             inter_r;
  logic             att_r;
  logic [1:0]       disp_r;
  logic [1:0]       cmd;
  logic             dest_pulse;

  // Result register.
  logic             out_valid;
  logic [1:0]       out_cmd;
  logic             out_pulse;
  logic [SEQ_W-1:0] out_seq;

  // Sequencer decisions.
  logic             tick_take;
  logic             out_load;
  logic             busy_disp;
  logic             cancel;
  logic [NOW_W-1:0] cmp_operand;
  logic             now_ge;
  logic             do_end;
  logic             do_start;
  logic             do_redraw;

  draw_req_t draw_req;
  draw_rsp_t draw_rsp;

  // Handshakes.
  assign cfg.ready  = 1'b1;
  assign tick.ready = (state == ST_IDLE);
  assign tick_take  = tick.valid && tick.ready;
  assign out_load   = (state == ST_DONE) && (!out_valid || result.ready);

  // Activity terms and the shared deadline compare.
  assign busy_disp   = inter_r || att_r || (disp_r != DISP_IDLE);
  assign cancel      = inter_r || att_r || (disp_r != DISP_ATTENTIVE);
  assign cmp_operand = ((state == ST_PULSE) && pulse_flag) ? pulse_end : next_quiet;
  assign now_ge      = now_r >= cmp_operand;
  assign do_end      = (state == ST_PULSE) && pulse_flag && (cancel || now_ge);
  assign do_start    = (state == ST_PULSE) && !pulse_flag && !busy_disp && now_ge;
  assign do_redraw   = (state == ST_CHECK) && busy_disp && !pulse_flag && now_ge;

  // Next state and draw requests.
  always_comb begin
    state_next        = state;
    ret_state_next    = ret_state;
    draw_req.start    = 1'b0;
    draw_req.is_pulse = 1'b0;
    draw_req.now      = now_r;
    draw_req.seq      = seq_count;
    case (state)
      ST_IDLE: begin
        draw_req.now = tick.now_ms;
        if (tick_take) begin
          if (!started) begin
            draw_req.start = 1'b1;
            ret_state_next = ST_PULSE;
            state_next     = ST_DRAW;
          end else begin
            state_next = ST_PULSE;
          end
        end
      end
      ST_PULSE: begin
        if (do_end) begin
          draw_req.start = 1'b1;
          draw_req.seq   = seq_count + 1'b1;
          ret_state_next = ST_CHECK;
          state_next     = ST_DRAW;
        end else if (do_start) begin
          draw_req.start    = 1'b1;
          draw_req.is_pulse = 1'b1;
          ret_state_next    = ST_CHECK;
          state_next        = ST_DRAW;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (do_redraw) begin
          draw_req.start = 1'b1;
          draw_req.seq   = seq_count + 1'b1;
          ret_state_next = ST_DONE;
          state_next     = ST_DRAW;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DRAW: begin
        if (draw_rsp.done) state_next = ret_state;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.min_quiet  <= MIN_QUIET_RST;
      cfg_regs.quiet_span <= QUIET_SPAN_RST;
      cfg_regs.pulse_min  <= PULSE_MIN_RST;
      cfg_regs.pulse_span <= PULSE_SPAN_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MIN_QUIET:  cfg_regs.min_quiet  <= cfg.data;
        REG_QUIET_SPAN: cfg_regs.quiet_span <= cfg.data;
        REG_PULSE_MIN:  cfg_regs.pulse_min  <= cfg.data;
        REG_PULSE_SPAN: cfg_regs.pulse_span <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Tick latch and draw destination.
  always_ff @(posedge clk) begin
    if (tick_take) begin
      now_r   <= tick.now_ms;
      inter_r <= tick.interaction;
      att_r   <= tick.attention;
      disp_r  <= tick.requested_state;
    end
    if (draw_req.start) begin
      dest_pulse <= draw_req.is_pulse;
    end
  end

  // Scheduler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_flag <= 1'b0;
      pulse_end  <= '0;
      next_quiet <= '0;
      seq_count  <= '0;
      started    <= 1'b0;
      cmd        <= CMD_NONE;
    end else begin
      if (tick_take) begin
        cmd     <= CMD_NONE;
        started <= 1'b1;
      end
      if (do_end) begin
        cmd        <= cancel ? CMD_NONE : CMD_IDLE;
        pulse_flag <= 1'b0;
        pulse_end  <= '0;
        seq_count  <= seq_count + 1'b1;
      end
      if (do_start) begin
        cmd        <= CMD_ATTENTIVE;
        pulse_flag <= 1'b1;
      end
      if (do_redraw) begin
        seq_count <= seq_count + 1'b1;
      end
      if ((state == ST_DRAW) && draw_rsp.done) begin
        if (dest_pulse) begin
          pulse_end <= draw_rsp.deadline;
        end else begin
          next_quiet <= draw_rsp.deadline;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cmd   <= cmd;
      out_pulse <= pulse_flag;
      out_seq   <= seq_count;
    end
  end

  assign result.valid         = out_valid;
  assign result.state_command = out_cmd;
  assign result.pulse_on      = out_pulse;
  assign result.sequence_out  = out_seq;

  // Shared deadline draw unit.
  jips_draw u_draw (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_regs),
    .req (draw_req),
    .rsp (draw_rsp)
  );

  `CHK_NEXT(a_tick_starts_work, clk, rst, tick_take, state != ST_IDLE, "tick accepted but sequencer idle")
  `CHK_IMP(a_quiet_before_start, clk, rst, !started, !pulse_flag && (seq_count == '0), "state changed before first tick")
  `CHK_IMP(a_draw_done_in_draw, clk, rst, draw_rsp.done, state == ST_DRAW, "draw finished outside draw wait")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jittered idle pulse scheduler testbench
// Drives time ticks and register writes into the scheduler, predicts each
// tick's command, pulse flag and sequence count, and compares every result
// in order. Stimulus is a directed opening followed by mostly well-behaved
// display sequences with random timing, activity noise and several register
// settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import jips_pkg::*;

  localparam logic [63:0]          TOP_MS         = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [1:0]           DISP_OTHER     = 2'd2;
  localparam logic [1:0]           DISP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 8'hFC;
  localparam int                   WATCHDOG_LIMIT = 2000;
  localparam int                   SETTLE_CYCLES  = 8;
  localparam int                   TAIL_CYCLES    = 150;
  localparam int                   HOLD_CYCLES    = 300;
  localparam int                   PHASE_ITEMS    = 86;

  typedef struct {
    logic [NOW_W-1:0] now;
    bit               inter;
    bit               att;
    logic [1:0]       st;
  } tick_t;

  typedef struct {
    logic [1:0]       cmd;
    bit               pulse;
    logic [SEQ_W-1:0] seq;
  } tick_outcome_t;

  // Tracks the scheduler state and holds the outcomes still owed by the block.
  class pulse_scoreboard;
    logic [CFG_DATA_W-1:0] min_quiet  = MIN_QUIET_RST;
    logic [CFG_DATA_W-1:0] quiet_span = QUIET_SPAN_RST;
    logic [CFG_DATA_W-1:0] pulse_min  = PULSE_MIN_RST;
    logic [CFG_DATA_W-1:0] pulse_span = PULSE_SPAN_RST;
    bit                    pulse_live   = 1'b0;
    logic [NOW_W-1:0]      pulse_due    = '0;
    logic [NOW_W-1:0]      quiet_due    = '0;
    logic [SEQ_W-1:0]      seq_count    = '0;
    bit                    armed        = 1'b0;
    int                    errors       = 0;
    int                    ticks_seen   = 0;
    tick_outcome_t         due_outcomes[$];

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      // Printing is capped so that a broken block cannot flood the log.
      if (errors < 100)
        $display("MISMATCH result %0d %s: got %0h expected %0h", ticks_seen, what, got,
                 want);
      errors++;
    endtask

    // Folds the seed to 32 bits and runs the 13/17/5 xorshift.
    function logic [31:0] mix32(logic [63:0] seed);
      logic [31:0] x;
      x = seed[31:0] ^ seed[63:32];
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
    endfunction

    // The time plus a base and a random extra below span, saturating at the top.
    function logic [63:0] stretch_deadline(logic [63:0] now, logic [15:0] base,
                                           logic [15:0] span, logic [31:0] r);
      logic [31:0] extra;
      logic [64:0] sum;
      extra = (span != 16'd0) ? (r % {16'd0, span}) : 32'd0;
      sum = {1'b0, now} + {49'd0, base} + {33'd0, extra};
      return sum[64] ? TOP_MS : sum[63:0];
    endfunction

    function logic [63:0] quiet_deadline(logic [63:0] now, logic [31:0] seq);
      logic [63:0] seed;
      seed = now + {32'd0, seq} * {32'd0, QUIET_MULT};
      return stretch_deadline(now, min_quiet, quiet_span, mix32(seed));
    endfunction

    function logic [63:0] pulse_deadline(logic [63:0] now, logic [31:0] seq);
      logic [63:0] seed;
      seed = (now << 1) ^ ({32'd0, seq} * {32'd0, PULSE_MULT});
      return stretch_deadline(now, pulse_min, pulse_span, mix32(seed));
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MIN_QUIET:  min_quiet  = val;
        REG_QUIET_SPAN: quiet_span = val;
        REG_PULSE_MIN:  pulse_min  = val;
        REG_PULSE_SPAN: pulse_span = val;
        default: ;
      endcase
    endfunction

    // Advances the schedule by one accepted tick and queues its outcome.
    function void note_tick(tick_t t);
      tick_outcome_t o;
      bit            busy;
      bit            cancel;
      o.cmd = CMD_NONE;
      busy = t.inter || t.att || (t.st != DISP_IDLE);
      if (!armed) begin
        quiet_due = quiet_deadline(t.now, seq_count);
        armed = 1'b1;
      end
      if (pulse_live) begin
        // Any activity, or a display that left attentive, cancels silently.
        cancel = t.inter || t.att || (t.st != DISP_ATTENTIVE);
        if (cancel || t.now >= pulse_due) begin
          if (!cancel)
            o.cmd = CMD_IDLE;
          pulse_live = 1'b0;
          pulse_due = '0;
          seq_count = seq_count + 1;
          quiet_due = quiet_deadline(t.now, seq_count);
        end
      end else if (!busy && t.now >= quiet_due) begin
        o.cmd = CMD_ATTENTIVE;
        pulse_live = 1'b1;
        pulse_due = pulse_deadline(t.now, seq_count);
      end
      // A quiet deadline that passed during activity is redrawn.
      if (busy && !pulse_live && t.now >= quiet_due) begin
        seq_count = seq_count + 1;
        quiet_due = quiet_deadline(t.now, seq_count);
      end
      o.pulse = pulse_live;
      o.seq = seq_count;
      due_outcomes.push_back(o);
    endfunction

    task check_result(logic [1:0] cmd, logic pulse, logic [SEQ_W-1:0] seq);
      tick_outcome_t o;
      ticks_seen++;
      if (due_outcomes.size() == 0) begin
        report_mismatch("with no tick waiting", {62'd0, cmd}, '0);
      end else begin
        o = due_outcomes.pop_front();
        if (cmd !== o.cmd)
          report_mismatch("state_command", {62'd0, cmd}, {62'd0, o.cmd});
        if (pulse !== o.pulse)
          report_mismatch("pulse_on", {63'd0, pulse}, {63'd0, o.pulse});
        if (seq !== o.seq)
          report_mismatch("sequence_out", {32'd0, seq}, {32'd0, o.seq});
      end
    endtask

    function int pending();
      return due_outcomes.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  jips_tick_if   tick_if ();
  jips_result_if res_if ();
  jips_cfg_if    cfg_if ();

  jittered_idle_pulse_scheduler dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .tick   (tick_if),
    .result (res_if)
  );

  pulse_scoreboard  sb;
  logic [NOW_W-1:0] clock_ms;
  bit               tick_calm;
  bit               result_calm;
  int               hold_req;
  int               idle_cycles;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none at all while calm.
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    if (roll < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Next tick time: small steps, some jumps across deadlines, rare steps back.
  function automatic logic [63:0] next_time(logic [63:0] t, int unsigned reach, bit clamp_top);
    logic [63:0] step;
    logic [64:0] sum;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 2)
      return t - 64'($urandom_range(0, 1000));
    if (roll < 70)
      step = 64'($urandom_range(0, 100));
    else if (roll < 90)
      step = 64'($urandom_range(0, reach / 4));
    else
      step = 64'($urandom_range(0, reach));
    sum = {1'b0, t} + {1'b0, step};
    if (sum[64] && clamp_top)
      return TOP_MS;
    return sum[63:0];
  endfunction

  function automatic cfg_t small_settings();
    cfg_t s;
    s.min_quiet  = 16'($urandom_range(0, 300));
    s.quiet_span = 16'($urandom_range(1, 500));
    s.pulse_min  = 16'($urandom_range(0, 100));
    s.pulse_span = 16'($urandom_range(1, 200));
    return s;
  endfunction

  // Offers one tick request after a random gap and notes it once accepted.
  task automatic send_tick(tick_t t);
    int gap;
    gap = pick_gap(tick_calm);
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid           <= 1'b1;
    tick_if.now_ms          <= t.now;
    tick_if.interaction     <= t.inter;
    tick_if.attention       <= t.att;
    tick_if.requested_state <= t.st;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic offer(logic [63:0] now, bit inter, bit att, logic [1:0] st);
    tick_t t;
    t.now = now;
    t.inter = inter;
    t.att = att;
    t.st = st;
    send_tick(t);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Registers change only once every owed result is back.
  task automatic apply_settings(cfg_t s, bit poke_unused);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_MIN_QUIET, s.min_quiet);
    write_reg(REG_QUIET_SPAN, s.quiet_span);
    write_reg(REG_PULSE_MIN, s.pulse_min);
    write_reg(REG_PULSE_SPAN, s.pulse_span);
    if (poke_unused)
      write_reg(REG_UNUSED, 16'($urandom));
    cfg_if.valid <= 1'b0;
    tick_calm   = ($urandom_range(0, 3) == 0);
    result_calm = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly a display that follows the commands, with bursts of activity and noise.
  task automatic run_phase(int count, bit near_top);
    tick_t       t;
    int          roll;
    int unsigned reach;
    reach = 2 * (int'(sb.min_quiet) + int'(sb.quiet_span) + int'(sb.pulse_min)
                 + int'(sb.pulse_span)) + 100;
    if (near_top)
      clock_ms = TOP_MS - 64'($urandom_range(0, 200000));
    repeat (count) begin
      clock_ms = next_time(clock_ms, reach, near_top);
      t.now = clock_ms;
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        t.inter = 1'b0;
        t.att = 1'b0;
        t.st = sb.pulse_live ? DISP_ATTENTIVE : DISP_IDLE;
        if (roll < 8)
          t.inter = 1'b1;
        else if (roll < 14)
          t.att = 1'b1;
        else if (roll < 18)
          t.st = DISP_OTHER;
      end else begin
        t.inter = 1'($urandom_range(0, 1));
        t.att = 1'($urandom_range(0, 1));
        t.st = 2'($urandom_range(0, 3));
      end
      send_tick(t);
    end
    tick_if.valid <= 1'b0;
  endtask

  // Result side: random back-pressure, plus a long hold when one is requested.
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = pick_gap(result_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.state_command, res_if.pulse_on, res_if.sequence_out);
  end

  // Ends the run when nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT after %0d cycles without a request", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : main
    sb = new();
    idle_cycles = 0;
    hold_req = 0;
    tick_calm = 1'b0;
    result_calm = 1'b0;
    clock_ms = '0;
    rst = 1'b1;
    tick_if.valid = 1'b0;
    tick_if.now_ms = '0;
    tick_if.interaction = 1'b0;
    tick_if.attention = 1'b0;
    tick_if.requested_state = DISP_IDLE;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening at reset settings: first tick, pulse start and timeout,
    // each kind of cancel, redraw under activity, saturation at the top of
    // time, and time going backwards.
    offer(64'd0, 1'b0, 1'b0, DISP_IDLE);
    offer(64'd20000, 1'b0, 1'b0, DISP_IDLE);
    offer(64'd20000, 1'b0, 1'b0, DISP_ATTENTIVE);
    offer(64'd21000, 1'b0, 1'b0, DISP_ATTENTIVE);
    offer(64'd21000, 1'b0, 1'b0, DISP_IDLE);
    offer(64'd50000, 1'b1, 1'b0, DISP_IDLE);
    offer(64'd80000, 1'b0, 1'b0, DISP_IDLE);
    offer(64'd80000, 1'b0, 1'b1, DISP_ATTENTIVE);
    offer(64'd110000, 1'b0, 1'b0, DISP_IDLE);
    offer(64'd110000, 1'b1, 1'b0, DISP_ATTENTIVE);
    offer(64'd140000, 1'b0, 1'b0, DISP_IDLE);
    offer(64'd140000, 1'b0, 1'b0, DISP_OTHER);
    offer(64'd170000, 1'b0, 1'b0, DISP_IDLE);
    offer(64'd170000, 1'b0, 1'b0, DISP_UNUSED);
    offer(64'd200000, 1'b0, 1'b0, DISP_OTHER);
    offer(TOP_MS - 64'd5, 1'b0, 1'b0, DISP_IDLE);
    offer(TOP_MS - 64'd5, 1'b0, 1'b0, DISP_ATTENTIVE);
    offer(TOP_MS, 1'b0, 1'b0, DISP_ATTENTIVE);
    offer(TOP_MS, 1'b0, 1'b0, DISP_IDLE);
    offer(64'd5, 1'b0, 1'b0, DISP_ATTENTIVE);
    offer(64'd5, 1'b1, 1'b1, DISP_IDLE);
    offer(64'd7, 1'b1, 1'b1, DISP_UNUSED);
    tick_if.valid <= 1'b0;
    clock_ms = 64'd7;

    // Zero spans and minimums: deadlines fall on the tick itself.
    apply_settings({16'd0, 16'd0, 16'd0, 16'd0}, 1'b1);
    run_phase(PHASE_ITEMS, 1'b0);
    apply_settings({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    run_phase(PHASE_ITEMS, 1'b0);

    // The result side holds off while ticks keep coming, so the block backs up.
    apply_settings(small_settings(), 1'b0);
    tick_calm = 1'b1;
    hold_req = HOLD_CYCLES;
    run_phase(PHASE_ITEMS, 1'b0);

    apply_settings({16'd0, 16'd1, 16'd0, 16'd1}, 1'b0);
    run_phase(PHASE_ITEMS, 1'b0);
    apply_settings(cfg_t'({$urandom, $urandom}), 1'b0);
    run_phase(PHASE_ITEMS, 1'b0);
    apply_settings(small_settings(), 1'b0);
    run_phase(PHASE_ITEMS, 1'b0);
    apply_settings({MIN_QUIET_RST, QUIET_SPAN_RST, PULSE_MIN_RST, PULSE_SPAN_RST}, 1'b0);
    run_phase(PHASE_ITEMS, 1'b0);

    // Last, since saturated deadlines near the top of time never come due again.
    apply_settings(small_settings(), 1'b0);
    run_phase(PHASE_ITEMS, 1'b1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
